// ===== design/lstk_pkg.sv =====
package lstk_pkg;

  // Default number of stack entries
  localparam int STACK_DEPTH_DEF = 16;

  // Field widths
  localparam int OP_W    = 3;
  localparam int DATA_W  = 32;
  localparam int COUNT_W = 5;

  // Operation codes
  localparam logic [OP_W-1:0] OP_PUSH     = 3'd0;
  localparam logic [OP_W-1:0] OP_POP      = 3'd1;
  localparam logic [OP_W-1:0] OP_PEEK     = 3'd2;
  localparam logic [OP_W-1:0] OP_CONTAINS = 3'd3;
  localparam logic [OP_W-1:0] OP_CLEAR    = 3'd4;

  // Command broadcast from the controller to every cell
  typedef struct packed {
    logic push;    // take the word from the cell above
    logic pop;     // take the word from the cell below
    logic clr;     // drop the entry
    logic load;    // latch the local compare result
    logic ripple;  // fold in the hit flag from the cell below
  } cell_cmd_t;

endpackage

// ===== design/lstk_cell.sv =====
module lstk_cell (
  input  logic                             clk,
  input  logic                             rst,
  input  lstk_pkg::cell_cmd_t              cmd,
  input  logic signed [lstk_pkg::DATA_W-1:0] search,
  input  logic signed [lstk_pkg::DATA_W-1:0] up_data,
  input  logic                             up_valid,
  input  logic signed [lstk_pkg::DATA_W-1:0] dn_data,
  input  logic                             dn_valid,
  input  logic                             dn_hit,
  output logic signed [lstk_pkg::DATA_W-1:0] cell_data,
  output logic                             cell_valid,
  output logic                             cell_hit
);

  // Shift the entry up or down the chain
  always_ff @(posedge clk) begin
    if (cmd.push) begin
      cell_data <= up_data;
    end else if (cmd.pop) begin
      cell_data <= dn_data;
    end
  end

  // Track whether this cell holds an entry
  always_ff @(posedge clk) begin
    if (rst || cmd.clr) begin
      cell_valid <= 1'b0;
    end else if (cmd.push) begin
      cell_valid <= up_valid;
    end else if (cmd.pop) begin
      cell_valid <= dn_valid;
    end
  end

  // Compare locally, then fold hits toward the top of the chain
  always_ff @(posedge clk) begin
    if (rst) begin
      cell_hit <= 1'b0;
    end else if (cmd.load) begin
      cell_hit <= cell_valid && (cell_data == search);
    end else if (cmd.ripple) begin
      cell_hit <= cell_hit | dn_hit;
    end
  end

endmodule

// ===== design/bounded_lifo_stack_with_search_core.sv =====
// Last-in-first-out stack of STACK_DEPTH signed 32-bit words built as a chain of
// cells; cell 0 is the top. Push, pop, peek and clear register their result at
// the edge that accepts the word. For contains, every cell compares its entry in
// the accept cycle, then the hit flags ripple one cell per cycle toward the top
// before the result is registered. The output register lets a new word be
// accepted in the cycle its predecessor's result is taken.
module bounded_lifo_stack_with_search_core #(
  parameter int STACK_DEPTH = lstk_pkg::STACK_DEPTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [lstk_pkg::OP_W-1:0]           operation,
  input  logic signed [lstk_pkg::DATA_W-1:0]  value,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic                                ok,
  output logic signed [lstk_pkg::DATA_W-1:0]  data,
  output logic [lstk_pkg::COUNT_W-1:0]        count,
  output logic                                is_empty,
  output logic                                is_full
);

  localparam int CW  = $clog2(STACK_DEPTH + 1);
  localparam int SCW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

  localparam logic ST_IDLE   = 1'b0;
  localparam logic ST_SEARCH = 1'b1;

  logic                               state;
  logic [SCW-1:0]                     scnt;
  logic [CW-1:0]                      depth_used;
  logic [CW-1:0]                      depth_next;
  logic [CW-1:0]                      res_depth;
  logic [CW+lstk_pkg::COUNT_W-1:0]    res_depth_ext;
  logic                               accept;
  logic                               out_free;
  logic                               finish;
  logic                               r_ok;
  logic signed [lstk_pkg::DATA_W-1:0] r_data;
  logic                               stk_empty;
  logic                               stk_full;
  lstk_pkg::cell_cmd_t                cmd;

  logic signed [lstk_pkg::DATA_W-1:0] cdata  [STACK_DEPTH];
  logic                               cvalid [STACK_DEPTH];
  logic                               chit   [STACK_DEPTH];

  // Build the chain; the input word enters at the top
  for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
    logic signed [lstk_pkg::DATA_W-1:0] up_d;
    logic                               up_v;
    logic signed [lstk_pkg::DATA_W-1:0] dn_d;
    logic                               dn_v;
    logic                               dn_h;

    if (i == 0) begin : g_top
      assign up_d = value;
      assign up_v = 1'b1;
    end else begin : g_mid
      assign up_d = cdata[i-1];
      assign up_v = cvalid[i-1];
    end

    if (i == STACK_DEPTH - 1) begin : g_bot
      assign dn_d = '0;
      assign dn_v = 1'b0;
      assign dn_h = 1'b0;
    end else begin : g_low
      assign dn_d = cdata[i+1];
      assign dn_v = cvalid[i+1];
      assign dn_h = chit[i+1];
    end

    lstk_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .cmd        (cmd),
      .search     (value),
      .up_data    (up_d),
      .up_valid   (up_v),
      .dn_data    (dn_d),
      .dn_valid   (dn_v),
      .dn_hit     (dn_h),
      .cell_data  (cdata[i]),
      .cell_valid (cvalid[i]),
      .cell_hit   (chit[i])
    );
  end

  // Handshake
  assign out_free = !out_valid || !out_stall;
  assign in_stall = (state != ST_IDLE) || !out_free;
  assign accept   = in_valid && !in_stall;
  assign finish   = (state == ST_SEARCH) && (scnt == '0) && out_free;

  assign stk_empty = (depth_used == '0);
  assign stk_full  = (depth_used == CW'(STACK_DEPTH));

  // Decode the operation into a chain command and a result
  always_comb begin
    depth_next = depth_used;
    r_ok       = 1'b0;
    r_data     = '0;
    cmd        = '0;
    if (accept) begin
      case (operation)
        lstk_pkg::OP_PUSH: begin
          if (!stk_full) begin
            cmd.push   = 1'b1;
            depth_next = depth_used + CW'(1);
            r_ok       = 1'b1;
          end
        end
        lstk_pkg::OP_POP: begin
          if (!stk_empty) begin
            cmd.pop    = 1'b1;
            depth_next = depth_used - CW'(1);
            r_data     = cdata[0];
            r_ok       = 1'b1;
          end
        end
        lstk_pkg::OP_PEEK: begin
          if (!stk_empty) begin
            r_data = cdata[0];
            r_ok   = 1'b1;
          end
        end
        lstk_pkg::OP_CONTAINS: begin
          cmd.load = 1'b1;
        end
        lstk_pkg::OP_CLEAR: begin
          cmd.clr    = 1'b1;
          depth_next = '0;
          r_ok       = 1'b1;
        end
        default: begin
        end
      endcase
    end else if ((state == ST_SEARCH) && (scnt != '0)) begin
      cmd.ripple = 1'b1;
    end
  end

  // Sequence the search
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      scnt  <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (accept && (operation == lstk_pkg::OP_CONTAINS)) begin
            state <= ST_SEARCH;
            scnt  <= SCW'(STACK_DEPTH - 1);
          end
        end
        ST_SEARCH: begin
          if (scnt != '0) begin
            scnt <= scnt - SCW'(1);
          end else if (finish) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Hold the entry count
  always_ff @(posedge clk) begin
    if (rst) begin
      depth_used <= '0;
    end else begin
      depth_used <= depth_next;
    end
  end

  // Load the result word, drop it once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((accept && (operation != lstk_pkg::OP_CONTAINS)) || finish) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && (operation != lstk_pkg::OP_CONTAINS)) begin
      ok        <= r_ok;
      data      <= r_data;
      res_depth <= depth_next;
    end else if (finish) begin
      ok        <= chit[0];
      data      <= '0;
      res_depth <= depth_used;
    end
  end

  // Derive the count and flags from the registered depth
  assign res_depth_ext = {{lstk_pkg::COUNT_W{1'b0}}, res_depth};
  assign count         = res_depth_ext[lstk_pkg::COUNT_W-1:0];
  assign is_empty      = (res_depth == '0);
  assign is_full       = (res_depth == CW'(STACK_DEPTH));

endmodule
